>>> hdl/multi_policy_cpu_scheduler_unit_defines.svh
// Assertion macros shared by the scheduler checker.
// Depends on nothing; included by the checker file.
`ifndef MULTI_POLICY_CPU_SCHEDULER_UNIT_DEFINES_SVH
`define MULTI_POLICY_CPU_SCHEDULER_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MPCS_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("scheduler check failed");
// Next-cycle implication checked outside reset.
`define MPCS_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("scheduler check failed");
`endif

>>> hdl/mpcs_pkg.sv
// Package of the multi-policy scheduler: codes, entry layout and types.
// Depends on nothing.
`timescale 1ns / 1ps
package mpcs_pkg;
  typedef enum logic [2:0] {
    ACT_WAKE = 3'd0, ACT_PREEMPT = 3'd1, ACT_YIELD = 3'd2,
    ACT_TERM = 3'd3, ACT_IDLE = 3'd4, ACT_PROGRESS = 3'd5
  } action_t;

  localparam logic [1:0] POL_RR = 2'd0;
  localparam logic [1:0] POL_FCFS = 2'd1;
  localparam logic [1:0] POL_PRIO = 2'd2;
  localparam logic [1:0] POL_SRTF = 2'd3;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_SLICE = 2'd1;
  localparam logic [1:0] CFG_CPUS = 2'd2;

  typedef struct packed {
    logic [31:0] arrival;
    logic [15:0] time_left;
    logic [7:0]  prio;
    logic [7:0]  id;
  } entry_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  cpu_index;
    logic [7:0]  task_id;
    logic [31:0] arrival_stamp;
    logic [7:0]  task_priority;
    logic [15:0] time_left;
  } in_word_t;

  typedef struct packed {
    logic        dispatch_done;
    logic        dispatch_has_task;
    logic [7:0]  dispatch_task;
    logic [15:0] dispatch_slice;
    logic        preempt_request;
    logic [2:0]  preempt_target;
    logic        queue_overflow;
  } out_word_t;

  // Policy key, zero-extended to the widest key; smaller is better.
  function automatic logic [31:0] policy_key(input logic [1:0] mode, input entry_t e);
    logic [31:0] k;
    k = 32'd0;
    case (mode)
      POL_FCFS: k = e.arrival;
      POL_PRIO: k = {24'd0, e.prio};
      POL_SRTF: k = {16'd0, e.time_left};
      default:  k = 32'd0;
    endcase
    return k;
  endfunction
endpackage

>>> hdl/mpcs_if.sv
// Valid/ready channel interface carrying one word of a given type.
// Depends on mpcs_pkg for the word types.
`timescale 1ns / 1ps
interface mpcs_in_if;
  logic valid;
  logic ready;
  mpcs_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mpcs_out_if;
  logic valid;
  logic ready;
  mpcs_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/mpcs_ram.sv
// Synchronous single-port-write, one-read memory with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module mpcs_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/multi_policy_cpu_scheduler_unit.sv
// Top level of the multi-policy CPU scheduler: sequencer, ready queue and
// CPU table memories. Depends on mpcs_pkg, mpcs_if and mpcs_ram.
//
// Usage: one event word enters on the in_ channel (valid/ready); exactly one
// result word leaves on the out_ channel for each event. Configuration is
// written through cfg_we/cfg_index/cfg_data while the block is idle.
// The ready queue lies in one synchronous memory kept in age order and the
// per-CPU running task records in a second one; busy flags are flip-flops.
// A wake that cannot preempt goes from decode straight to its result word;
// a wake that must scan the CPU table first reads the table records.
// A dispatch scans the queue one entry per cycle to find the best, then
// closes the gap by copying later entries down one a cycle.
// One event is worked at a time; the next is taken only once the previous
// result word has been taken by the receiver.
// Reset (synchronous, rst_n low) empties the queue, marks all CPUs idle and
// loads the register resets; memory contents need no clearing because only
// written entries are read.
// When the receiver stalls the result word holds in the output register
// and no new event is accepted until it is taken.
module multi_policy_cpu_scheduler_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_CPUS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  mpcs_in_if.sink     in_ch,
  mpcs_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int CAW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int CCW = $clog2(MAX_CPUS + 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_DECODE = 10'b0000000010,
    S_TREAD = 10'b0000000100, S_TSCAN = 10'b0000001000,
    S_QSCAN = 10'b0000010000, S_QSHIFT = 10'b0000100000,
    S_SHWR = 10'b0001000000, S_FIN = 10'b0010000000,
    S_OUT = 10'b0100000000, S_PRE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0]  mode_r;
  logic [15:0] slice_r;
  logic [3:0]  cpus_r;
  mpcs_pkg::in_word_t ev_r;
  mpcs_pkg::out_word_t res_r;
  logic out_valid_r;
  logic [QCW-1:0] count_r;
  logic [MAX_CPUS-1:0] busy_r;
  logic [QAW-1:0] qi_r, best_r;
  logic [31:0] best_key_r;
  mpcs_pkg::entry_t best_e_r;
  logic [CCW-1:0] ci_r;
  logic [CAW-1:0] worst_r;
  logic [31:0] worst_key_r;
  logic first_r;

  // Memory ports.
  logic q_we, t_we;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [CAW-1:0] t_waddr, t_raddr;
  logic [63:0] q_wdata, q_rdata, t_wdata, t_rdata;
  mpcs_pkg::entry_t q_re, t_re, new_e, pre_e;

  mpcs_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(64)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata));
  mpcs_ram #(.DEPTH(MAX_CPUS), .WIDTH(64)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata));

  assign q_re = mpcs_pkg::entry_t'(q_rdata);
  assign t_re = mpcs_pkg::entry_t'(t_rdata);

  // Effective CPU count, clamped to one and MAX_CPUS.
  logic [CCW-1:0] ncpu;
  always_comb begin
    if (cpus_r == 4'd0) ncpu = CCW'(1);
    else if (32'(cpus_r) > MAX_CPUS) ncpu = CCW'(MAX_CPUS);
    else ncpu = CCW'(cpus_r);
  end

  logic cpu_ok, all_busy, q_full;
  logic [CAW-1:0] cpu;
  assign cpu = CAW'(ev_r.cpu_index);
  assign cpu_ok = 32'(ev_r.cpu_index) < 32'(ncpu);
  assign q_full = 32'(count_r) >= QUEUE_DEPTH;
  always_comb begin
    all_busy = 1'b1;
    for (int i = 0; i < MAX_CPUS; i++)
      if (i < 32'(ncpu) && !busy_r[i]) all_busy = 1'b0;
  end

  assign new_e = '{arrival: ev_r.arrival_stamp, time_left: ev_r.time_left,
                   prio: ev_r.task_priority, id: ev_r.task_id};
  always_comb begin
    pre_e = t_re;
    pre_e.time_left = ev_r.time_left;
  end

  logic [31:0] qkey, tkey;
  assign qkey = mpcs_pkg::policy_key(mode_r, q_re);
  assign tkey = mpcs_pkg::policy_key(mode_r, t_re);

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = res_r;

  logic [2:0] act;
  assign act = ev_r.action;

  // Next state and memory control.
  always_comb begin
    state_nxt = state_r;
    q_we = 1'b0; q_waddr = count_r[QAW-1:0]; q_wdata = 64'(new_e);
    q_raddr = qi_r;
    t_we = 1'b0; t_waddr = cpu; t_wdata = 64'(pre_e);
    t_raddr = cpu;
    unique case (state_r)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_nxt = S_DECODE;
      S_DECODE: begin
        if (act == mpcs_pkg::ACT_WAKE) begin
          q_we = !q_full;
          if (q_full || !(mode_r == mpcs_pkg::POL_PRIO || mode_r == mpcs_pkg::POL_SRTF)
              || !all_busy) state_nxt = S_OUT;
          else state_nxt = S_TREAD;
        end else if (act > mpcs_pkg::ACT_PROGRESS || !cpu_ok) begin
          state_nxt = S_OUT;
        end else if (act == mpcs_pkg::ACT_PREEMPT || act == mpcs_pkg::ACT_PROGRESS) begin
          state_nxt = S_PRE;
        end else begin
          state_nxt = (count_r == '0) ? S_FIN : S_QSCAN;
        end
        t_raddr = cpu;
        q_raddr = '0;
      end
      S_PRE: begin
        // Table record of this CPU is on the read port now.
        if (act == mpcs_pkg::ACT_PROGRESS) begin
          t_we = busy_r[cpu];
          state_nxt = S_OUT;
        end else begin
          if (busy_r[cpu] && !q_full) begin
            q_we = 1'b1; q_wdata = 64'(pre_e);
          end
          // With an empty queue the only candidate is the task put back, which
          // is taken straight from the table read rather than the queue.
          state_nxt = (count_r == '0) ? S_FIN : S_QSCAN;
        end
        q_raddr = '0;
      end
      S_TREAD: begin
        t_raddr = '0;
        state_nxt = S_TSCAN;
      end
      S_TSCAN: begin
        t_raddr = CAW'(ci_r + CCW'(1));
        if (ci_r + CCW'(1) >= ncpu) state_nxt = S_OUT;
      end
      S_QSCAN: begin
        q_raddr = QAW'(qi_r + QAW'(1));
        if (32'(qi_r) + 1 >= 32'(count_r)) begin
          state_nxt = S_QSHIFT;
        end
      end
      S_QSHIFT: begin
        // Read entry after the gap.
        q_raddr = QAW'(qi_r + QAW'(1));
        if (32'(qi_r) + 1 >= 32'(count_r)) state_nxt = S_FIN;
        else state_nxt = S_SHWR;
      end
      S_SHWR: begin
        q_we = 1'b1; q_waddr = qi_r; q_wdata = q_rdata;
        q_raddr = QAW'(qi_r + QAW'(2));
        if (32'(qi_r) + 2 >= 32'(count_r)) state_nxt = S_FIN;
      end
      S_FIN: begin
        t_we = (count_r != '0);
        t_wdata = 64'(best_e_r);
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r <= mpcs_pkg::POL_FCFS;
      slice_r <= '0;
      cpus_r <= 4'd1;
      out_valid_r <= 1'b0;
      count_r <= '0;
      busy_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mpcs_pkg::CFG_MODE:  mode_r <= cfg_data[1:0];
          mpcs_pkg::CFG_SLICE: slice_r <= cfg_data;
          mpcs_pkg::CFG_CPUS:  cpus_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          ev_r <= in_ch.data;
          res_r <= '0;
        end
        S_DECODE: begin
          if (act == mpcs_pkg::ACT_WAKE) begin
            if (q_full) res_r.queue_overflow <= 1'b1;
            else count_r <= count_r + QCW'(1);
          end
          qi_r <= '0; best_r <= '0; first_r <= 1'b1;
          ci_r <= '0; worst_r <= '0;
        end
        S_PRE: begin
          if (act != mpcs_pkg::ACT_PROGRESS && busy_r[cpu]) begin
            if (q_full) res_r.queue_overflow <= 1'b1;
            else count_r <= count_r + QCW'(1);
          end
          if (count_r == '0) best_e_r <= pre_e;
        end
        S_TSCAN: begin
          if (ci_r == '0 || tkey > worst_key_r) begin
            worst_r <= CAW'(ci_r);
            worst_key_r <= tkey;
          end
          ci_r <= ci_r + CCW'(1);
          if (ci_r + CCW'(1) >= ncpu) begin
            if (mpcs_pkg::policy_key(mode_r, new_e) <
                ((ci_r == '0 || tkey > worst_key_r) ? tkey : worst_key_r)) begin
              res_r.preempt_request <= 1'b1;
              res_r.preempt_target <= 3'((ci_r == '0 || tkey > worst_key_r) ?
                                         CAW'(ci_r) : worst_r);
            end
          end
        end
        S_QSCAN: begin
          if (first_r || (mode_r != mpcs_pkg::POL_RR && qkey < best_key_r)) begin
            best_r <= qi_r; best_key_r <= qkey; best_e_r <= q_re;
          end
          first_r <= 1'b0;
          if (32'(qi_r) + 1 >= 32'(count_r)) begin
            qi_r <= (first_r || (mode_r != mpcs_pkg::POL_RR && qkey < best_key_r)) ?
                    qi_r : best_r;
          end else qi_r <= qi_r + QAW'(1);
        end
        S_SHWR: qi_r <= qi_r + QAW'(1);
        S_FIN: begin
          res_r.dispatch_done <= 1'b1;
          if (count_r == '0) begin
            busy_r[cpu] <= 1'b0;
          end else begin
            busy_r[cpu] <= 1'b1;
            count_r <= count_r - QCW'(1);
            res_r.dispatch_has_task <= 1'b1;
            res_r.dispatch_task <= best_e_r.id;
            res_r.dispatch_slice <= (mode_r == mpcs_pkg::POL_RR) ? slice_r : 16'd0;
          end
        end
        S_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
      if (state_r == S_PRE && act != mpcs_pkg::ACT_PROGRESS) busy_r[cpu] <= 1'b0;
      if (state_r == S_DECODE && act >= mpcs_pkg::ACT_YIELD && act <= mpcs_pkg::ACT_IDLE
          && cpu_ok) busy_r[cpu] <= 1'b0;
    end
  end
endmodule

>>> hdl/mpcs_checker.sv
// Port-level checker for the scheduler, bound to the top level.
// Depends on the defines header and mpcs_pkg.
`timescale 1ns / 1ps
`include "multi_policy_cpu_scheduler_unit_defines.svh"
module mpcs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input mpcs_pkg::out_word_t out_data
);
  `MPCS_ASSERT_IMP(a_no_task_no_slice, clk, rst_n, out_valid && !out_data.dispatch_has_task, out_data.dispatch_slice == 16'd0)
  `MPCS_ASSERT_IMP(a_has_needs_done, clk, rst_n, out_valid && out_data.dispatch_has_task, out_data.dispatch_done)
  `MPCS_ASSERT_IMP(a_no_take_while_full, clk, rst_n, out_valid, !in_ready)
  `MPCS_ASSERT_NXT(a_accept_blocks, clk, rst_n, in_valid && in_ready, !in_ready)
  `MPCS_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind multi_policy_cpu_scheduler_unit mpcs_checker u_mpcs_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));

>>> tb/tb_multi_policy_cpu_scheduler_unit.sv
// Self-checking testbench of the multi-policy CPU scheduler: directed and random
// event words are predicted by a behavioural scheduler model and results compared.
// Depends on mpcs_pkg, mpcs_if and the scheduler RTL.
`timescale 1ns / 1ps
module tb_multi_policy_cpu_scheduler_unit;
  localparam int QDEPTH = 16;
  localparam int NCPU = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] ACT_UNUSED_LO = mpcs_pkg::ACT_PROGRESS + 3'd1;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  mpcs_in_if in_ch ();
  mpcs_out_if out_ch ();

  multi_policy_cpu_scheduler_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Event words waiting to be offered, and result words still owed by the block.
  mpcs_pkg::in_word_t event_q[$];
  mpcs_pkg::out_word_t owed_results[$];
  int fail_count = 0;
  int results_seen = 0;

  // Shadow of the scheduler state: ready queue in age order and the CPU table.
  mpcs_pkg::entry_t ready_q[QDEPTH];
  int ready_n;
  bit cpu_running[NCPU];
  mpcs_pkg::entry_t cpu_rec[NCPU];
  logic [1:0] pol_mode;
  logic [15:0] pol_slice;
  logic [3:0] pol_cpus;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Ordering key under the current policy; a smaller key wins.
  function automatic logic [31:0] rank(mpcs_pkg::entry_t e);
    case (pol_mode)
      mpcs_pkg::POL_FCFS: return e.arrival;
      mpcs_pkg::POL_PRIO: return {24'd0, e.prio};
      mpcs_pkg::POL_SRTF: return {16'd0, e.time_left};
      default: return 32'd0;
    endcase
  endfunction

  function automatic int cpus_active();
    if (pol_cpus == 4'd0) return 1;
    if (pol_cpus > NCPU) return NCPU;
    return int'(pol_cpus);
  endfunction

  function automatic bit push_ready(mpcs_pkg::entry_t e);
    if (ready_n >= QDEPTH) return 1'b0;
    ready_q[ready_n] = e;
    ready_n++;
    return 1'b1;
  endfunction

  // Picks the next task for a CPU, or leaves it idle when nothing is ready.
  function automatic void pick_task(int c, inout mpcs_pkg::out_word_t r);
    int best;
    mpcs_pkg::entry_t e;
    best = 0;
    r.dispatch_done = 1'b1;
    if (ready_n == 0) begin
      cpu_running[c] = 1'b0;
      cpu_rec[c] = '0;
      return;
    end
    if (pol_mode != mpcs_pkg::POL_RR) begin
      for (int i = 1; i < ready_n; i++)
        if (rank(ready_q[i]) < rank(ready_q[best])) best = i;
    end
    e = ready_q[best];
    for (int i = best; i + 1 < ready_n; i++) ready_q[i] = ready_q[i + 1];
    ready_n--;
    cpu_running[c] = 1'b1;
    cpu_rec[c] = e;
    r.dispatch_has_task = 1'b1;
    r.dispatch_task = e.id;
    r.dispatch_slice = (pol_mode == mpcs_pkg::POL_RR) ? pol_slice : 16'd0;
  endfunction

  function automatic mpcs_pkg::out_word_t schedule_event(mpcs_pkg::in_word_t w);
    mpcs_pkg::out_word_t r;
    mpcs_pkg::entry_t e;
    int c;
    int worst;
    bit all_busy;
    r = '0;
    c = int'(w.cpu_index);
    if (w.action == mpcs_pkg::ACT_WAKE) begin
      e = '{arrival: w.arrival_stamp, time_left: w.time_left,
            prio: w.task_priority, id: w.task_id};
      if (!push_ready(e)) begin
        r.queue_overflow = 1'b1;
        return r;
      end
      if (pol_mode != mpcs_pkg::POL_PRIO && pol_mode != mpcs_pkg::POL_SRTF) return r;
      all_busy = 1'b1;
      for (int i = 0; i < cpus_active(); i++)
        if (!cpu_running[i]) all_busy = 1'b0;
      if (!all_busy) return r;
      // The first CPU with the worst key is the one asked to give way.
      worst = 0;
      for (int i = 1; i < cpus_active(); i++)
        if (rank(cpu_rec[i]) > rank(cpu_rec[worst])) worst = i;
      if (rank(e) < rank(cpu_rec[worst])) begin
        r.preempt_request = 1'b1;
        r.preempt_target = 3'(worst);
      end
      return r;
    end
    if (w.action > mpcs_pkg::ACT_PROGRESS || c >= cpus_active()) return r;
    case (w.action)
      mpcs_pkg::ACT_PREEMPT: begin
        if (cpu_running[c]) begin
          e = cpu_rec[c];
          e.time_left = w.time_left;
          cpu_running[c] = 1'b0;
          if (!push_ready(e)) r.queue_overflow = 1'b1;
        end
        pick_task(c, r);
      end
      mpcs_pkg::ACT_YIELD, mpcs_pkg::ACT_TERM, mpcs_pkg::ACT_IDLE: begin
        cpu_running[c] = 1'b0;
        pick_task(c, r);
      end
      default: begin
        if (cpu_running[c]) cpu_rec[c].time_left = w.time_left;
      end
    endcase
    return r;
  endfunction

  // Register writes happen only with the block idle, so the shadow copy is
  // updated at once.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      mpcs_pkg::CFG_MODE: pol_mode = val[1:0];
      mpcs_pkg::CFG_SLICE: pol_slice = val;
      default: pol_cpus = val[3:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (event_q.size() != 0 || in_ch.valid || owed_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic mpcs_pkg::in_word_t make_event(logic [2:0] act, logic [2:0] c,
                                                    logic [7:0] id, logic [31:0] arr,
                                                    logic [7:0] pr, logic [15:0] tl);
    mpcs_pkg::in_word_t w;
    w.action = act;
    w.cpu_index = c;
    w.task_id = id;
    w.arrival_stamp = arr;
    w.task_priority = pr;
    w.time_left = tl;
    return w;
  endfunction

  // Random traffic: mostly wakes and dispatching events on live CPUs, with
  // keys often drawn from a narrow range so that ties are common.
  task automatic queue_random(int n, int wake_pct);
    mpcs_pkg::in_word_t w;
    for (int k = 0; k < n; k++) begin
      w = mpcs_pkg::in_word_t'(70'({$urandom, $urandom, $urandom}));
      if ($urandom_range(0, 99) < 3)
        w.action = 3'($urandom_range(int'(ACT_UNUSED_LO), 7));
      else if ($urandom_range(0, 99) < wake_pct)
        w.action = mpcs_pkg::ACT_WAKE;
      else
        w.action = 3'($urandom_range(int'(mpcs_pkg::ACT_PREEMPT),
                                     int'(mpcs_pkg::ACT_PROGRESS)));
      if ($urandom_range(0, 9) != 0) w.cpu_index = 3'($urandom_range(0, cpus_active() - 1));
      if ($urandom_range(0, 1) != 0) w.task_priority = 8'($urandom_range(0, 3));
      if ($urandom_range(0, 1) != 0) w.time_left = 16'($urandom_range(0, 7));
      if ($urandom_range(0, 1) != 0) w.arrival_stamp = $urandom_range(0, 7);
      event_q.push_back(w);
    end
  endtask

  // Driver: a new word is presented once the previous one has been taken.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) owed_results.push_back(schedule_event(in_ch.data));
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (event_q.size() != 0) begin
          in_ch.data <= event_q.pop_front();
          in_ch.valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: random back-pressure plus one long hold to fill the block.
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    mpcs_pkg::out_word_t want;
    mpcs_pkg::out_word_t got;
    logic next_ready;
    if (rst_n) begin
      next_ready = 1'b1;
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        results_seen++;
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result word %0h", $realtime, got);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("dispatch_done", 32'(want.dispatch_done), 32'(got.dispatch_done));
          check_field("dispatch_has_task", 32'(want.dispatch_has_task),
                      32'(got.dispatch_has_task));
          check_field("dispatch_task", 32'(want.dispatch_task), 32'(got.dispatch_task));
          check_field("dispatch_slice", 32'(want.dispatch_slice), 32'(got.dispatch_slice));
          check_field("preempt_request", 32'(want.preempt_request),
                      32'(got.preempt_request));
          check_field("preempt_target", 32'(want.preempt_target), 32'(got.preempt_target));
          check_field("queue_overflow", 32'(want.queue_overflow), 32'(got.queue_overflow));
        end
        recv_gap <= pick_gap();
      end
      if (!hold_done && results_seen == 600) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        next_ready = 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        next_ready = 1'b0;
      end else if (recv_gap > 0 && !(out_ch.valid && out_ch.ready)) begin
        recv_gap <= recv_gap - 1;
        next_ready = 1'b0;
      end
      out_ch.ready <= next_ready;
    end
  end

  // Watchdog: a stretch with no handshake on either side that reaches the limit ends the run as a failure.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = mpcs_pkg::CFG_MODE;
    cfg_data = 16'd0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    ready_n = 0;
    for (int i = 0; i < NCPU; i++) begin
      cpu_running[i] = 1'b0;
      cpu_rec[i] = '0;
    end
    pol_mode = mpcs_pkg::POL_FCFS;
    pol_slice = 16'd0;
    pol_cpus = 4'd1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: two CPUs under priority scheduling.
    write_reg(mpcs_pkg::CFG_MODE, 16'(mpcs_pkg::POL_PRIO));
    write_reg(mpcs_pkg::CFG_CPUS, 16'd2);
    write_reg(mpcs_pkg::CFG_SLICE, 16'd50);
    // Dispatch with nothing ready leaves the CPU idle.
    event_q.push_back(make_event(mpcs_pkg::ACT_IDLE, 3'd0, 8'd0, 32'd0, 8'd0, 16'd0));
    event_q.push_back(make_event(mpcs_pkg::ACT_WAKE, 3'd0, 8'd1, 32'd5, 8'd10, 16'd100));
    event_q.push_back(make_event(mpcs_pkg::ACT_WAKE, 3'd7, 8'd2, 32'd6, 8'd5, 16'd200));
    event_q.push_back(make_event(mpcs_pkg::ACT_IDLE, 3'd0, 8'd0, 32'd0, 8'd0, 16'd0));
    // A wake while a CPU is still idle never asks for preemption.
    event_q.push_back(make_event(mpcs_pkg::ACT_WAKE, 3'd0, 8'd3, 32'd7, 8'd0, 16'd1));
    event_q.push_back(make_event(mpcs_pkg::ACT_IDLE, 3'd1, 8'd0, 32'd0, 8'd0, 16'd0));
    // Both CPUs busy: a better task asks the worse one to give way.
    event_q.push_back(make_event(mpcs_pkg::ACT_WAKE, 3'd0, 8'd255, 32'hFFFF_FFFF, 8'd1,
                                 16'hFFFF));
    event_q.push_back(make_event(mpcs_pkg::ACT_WAKE, 3'd0, 8'd4, 32'd0, 8'd255, 16'd0));
    event_q.push_back(make_event(mpcs_pkg::ACT_PREEMPT, 3'd1, 8'd0, 32'd0, 8'd0, 16'hFFFF));
    event_q.push_back(make_event(mpcs_pkg::ACT_PROGRESS, 3'd0, 8'd0, 32'd0, 8'd0, 16'd0));
    event_q.push_back(make_event(mpcs_pkg::ACT_YIELD, 3'd0, 8'd0, 32'd0, 8'd0, 16'd0));
    event_q.push_back(make_event(mpcs_pkg::ACT_TERM, 3'd1, 8'd0, 32'd0, 8'd0, 16'd0));
    // CPU outside the scheduled set, and the unused action codes, are ignored.
    event_q.push_back(make_event(mpcs_pkg::ACT_YIELD, 3'd7, 8'd0, 32'd0, 8'd0, 16'd0));
    event_q.push_back(make_event(ACT_UNUSED_LO, 3'd0, 8'd0, 32'd0, 8'd0, 16'd0));
    event_q.push_back(make_event(3'd7, 3'd0, 8'd0, 32'd0, 8'd0, 16'd0));
    event_q.push_back(make_event(mpcs_pkg::ACT_TERM, 3'd0, 8'd0, 32'd0, 8'd0, 16'd0));
    event_q.push_back(make_event(mpcs_pkg::ACT_TERM, 3'd1, 8'd0, 32'd0, 8'd0, 16'd0));
    // Preempting an idle CPU enqueues nothing; progress on an idle CPU is dropped.
    event_q.push_back(make_event(mpcs_pkg::ACT_PREEMPT, 3'd1, 8'd0, 32'd0, 8'd0, 16'd9));
    event_q.push_back(make_event(mpcs_pkg::ACT_PROGRESS, 3'd1, 8'd0, 32'd0, 8'd0, 16'd9));
    event_q.push_back(make_event(mpcs_pkg::ACT_IDLE, 3'd0, 8'd0, 32'd0, 8'd0, 16'd0));
    event_q.push_back(make_event(mpcs_pkg::ACT_IDLE, 3'd1, 8'd0, 32'd0, 8'd0, 16'd0));
    wait_drained();

    // Random phases across policies, slices and CPU counts, extremes included.
    write_reg(mpcs_pkg::CFG_MODE, 16'(mpcs_pkg::POL_RR));
    write_reg(mpcs_pkg::CFG_SLICE, 16'd0);
    write_reg(mpcs_pkg::CFG_CPUS, 16'd1);
    queue_random(240, 50);
    wait_drained();
    write_reg(mpcs_pkg::CFG_SLICE, 16'hFFFF);
    write_reg(mpcs_pkg::CFG_CPUS, 16'd8);
    queue_random(240, 75);
    wait_drained();
    write_reg(mpcs_pkg::CFG_MODE, 16'(mpcs_pkg::POL_FCFS));
    write_reg(mpcs_pkg::CFG_CPUS, 16'd4);
    queue_random(240, 55);
    wait_drained();
    write_reg(mpcs_pkg::CFG_MODE, 16'(mpcs_pkg::POL_PRIO));
    write_reg(mpcs_pkg::CFG_CPUS, 16'd15);
    queue_random(240, 60);
    wait_drained();
    write_reg(mpcs_pkg::CFG_MODE, 16'(mpcs_pkg::POL_SRTF));
    write_reg(mpcs_pkg::CFG_CPUS, 16'd0);
    queue_random(240, 50);
    wait_drained();
    write_reg(mpcs_pkg::CFG_MODE, 16'(mpcs_pkg::POL_PRIO));
    write_reg(mpcs_pkg::CFG_CPUS, 16'd3);
    queue_random(240, 55);
    wait_drained();
    write_reg(mpcs_pkg::CFG_MODE, 16'(mpcs_pkg::POL_SRTF));
    write_reg(mpcs_pkg::CFG_CPUS, 16'd8);
    queue_random(240, 70);
    wait_drained();
    write_reg(mpcs_pkg::CFG_MODE, 16'(mpcs_pkg::POL_RR));
    write_reg(mpcs_pkg::CFG_SLICE, 16'($urandom));
    write_reg(mpcs_pkg::CFG_CPUS, 16'd2);
    queue_random(240, 50);
    wait_drained();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+hdl
hdl/mpcs_pkg.sv
hdl/mpcs_if.sv
hdl/mpcs_ram.sv
hdl/multi_policy_cpu_scheduler_unit.sv
hdl/mpcs_checker.sv
tb/tb_multi_policy_cpu_scheduler_unit.sv
